[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the core RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("core assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_PROP(label, clk, rst, !(expr))

`endif

[rtl/core/hbp_pkg.sv]
// ----------------------------------------------------------------------------
// hbp_pkg
// Types and constants shared by the Huffman bit packer core
// ----------------------------------------------------------------------------
package hbp_pkg;

   // command field codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   // field widths
   localparam int CMD_W      = 2;
   localparam int SYMBOL_W   = 8;
   localparam int WORD_BITS  = 32;
   localparam int LEN_W      = 6;
   localparam int BYTE_BITS  = 8;
   localparam int PEND_W     = 7;
   localparam int PCNT_W     = 3;
   // left aligned work window: seven pending bits plus a full code word
   localparam int WORK_BITS  = 40;
   localparam int TOTAL_W    = 6;

   // controller to datapath commands
   typedef struct packed {
      logic mem_wr;
      logic mem_rd;
      logic align_ld;
      logic flush_ld;
      logic emit;
   } hbp_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic sym_ok;
      logic pend_nonzero;
      logic align_ge8;
      logic emit_last;
      logic out_free;
   } hbp_stat_type;

endpackage

[rtl/core/hbp_if.sv]
// ----------------------------------------------------------------------------
// hbp_if
// Request and response channel interfaces of the bit packer
// ----------------------------------------------------------------------------
interface hbp_req_if import hbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [SYMBOL_W-1:0]  symbol;
   logic [WORD_BITS-1:0] code_word;
   logic [LEN_W-1:0]     code_length;

   modport source (output valid, cmd, symbol, code_word, code_length, input ready);
   modport sink   (input valid, cmd, symbol, code_word, code_length, output ready);
endinterface

interface hbp_rsp_if import hbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] packed_byte;
   logic                 last;

   modport source (output valid, packed_byte, last, input ready);
   modport sink   (input valid, packed_byte, last, output ready);
endinterface

[rtl/core/hbp_datapath.sv]
// ----------------------------------------------------------------------------
// hbp_datapath
// Code table, bit alignment, pending bits and output byte register
// ----------------------------------------------------------------------------
module hbp_datapath import hbp_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hbp_ctrl_type         ctrl,
   output hbp_stat_type         stat,
   input  logic [SYMBOL_W-1:0]  req_symbol,
   input  logic [WORD_BITS-1:0] req_code_word,
   input  logic [LEN_W-1:0]     req_code_length,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [BYTE_BITS-1:0] rsp_packed_byte,
   output logic                 rsp_last
);

   localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int LEN_CAP = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
   localparam int ENTRY_W = LEN_W + WORD_BITS;

   // low n bits set, saturating at the pending width
   function automatic logic [PEND_W-1:0] lo_mask(input logic [LEN_W-1:0] n);
      logic [PEND_W-1:0] ones;
      ones = '1;
      if (n >= LEN_W'(PEND_W)) return ones;
      else return ~(ones << n);
   endfunction

   logic [ENTRY_W-1:0]   tbl_mem [SYMBOLS];
   logic [ENTRY_W-1:0]   rd_entry_ff;
   logic [IDX_W-1:0]     idx;
   logic [LEN_W-1:0]     len_sat;

   logic [PEND_W-1:0]    pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]    pend_cnt_ff, pend_cnt_in;
   logic [WORK_BITS-1:0] work_ff, work_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_BITS-1:0] out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;

   logic [LEN_W-1:0]     rd_len;
   logic [WORD_BITS-1:0] rd_code;
   logic [WORD_BITS-1:0] code_al;
   logic [PEND_W-1:0]    pend_al;
   logic [WORK_BITS-1:0] align_work;
   logic [TOTAL_W-1:0]   align_total;
   logic [PEND_W-1:0]    stream_lo;
   logic [PEND_W-1:0]    align_pend;
   logic [BYTE_BITS-1:0] flush_byte;

   assign idx     = req_symbol[IDX_W-1:0];
   assign len_sat = (int'(req_code_length) > LEN_CAP) ? LEN_W'(LEN_CAP) : req_code_length;

   // code table write port
   always_ff @(posedge clock) begin
      if (ctrl.mem_wr) begin
         tbl_mem[idx] <= {len_sat, req_code_word};
      end
   end

   // code table registered read port
   always_ff @(posedge clock) begin
      if (ctrl.mem_rd) begin
         rd_entry_ff <= tbl_mem[idx];
      end
   end

   assign rd_len  = rd_entry_ff[ENTRY_W-1:WORD_BITS];
   assign rd_code = rd_entry_ff[WORD_BITS-1:0];

   // left align pending bits and code word into one window
   always_comb begin
      code_al     = rd_code << (LEN_W'(WORD_BITS) - rd_len);
      pend_al     = pend_bits_ff << (PCNT_W'(PEND_W) - pend_cnt_ff);
      align_work  = {pend_al, {(WORK_BITS-PEND_W){1'b0}}}
                  | ({code_al, {BYTE_BITS{1'b0}}} >> pend_cnt_ff);
      align_total = TOTAL_W'(pend_cnt_ff) + TOTAL_W'(rd_len);
      // leftover bits after whole bytes are the low end of the bit stream
      stream_lo   = (pend_bits_ff << rd_len) | (rd_code[PEND_W-1:0] & lo_mask(rd_len));
      align_pend  = stream_lo & lo_mask(LEN_W'(align_total[PCNT_W-1:0]));
   end

   // pending bits padded with zeros at the low end
   assign flush_byte = {1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff});

   // next state of work window, pending bits and output register
   always_comb begin
      work_in      = work_ff;
      total_in     = total_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (ctrl.align_ld) begin
         work_in      = align_work;
         total_in     = align_total;
         pend_bits_in = align_pend;
         pend_cnt_in  = align_total[PCNT_W-1:0];
      end
      if (ctrl.flush_ld) begin
         work_in      = {flush_byte, {(WORK_BITS-BYTE_BITS){1'b0}}};
         total_in     = TOTAL_W'(BYTE_BITS);
         pend_bits_in = '0;
         pend_cnt_in  = '0;
      end
      if (ctrl.emit) begin
         work_in      = work_ff << BYTE_BITS;
         total_in     = total_ff - TOTAL_W'(BYTE_BITS);
         out_byte_in  = work_ff[WORK_BITS-1 -: BYTE_BITS];
         out_last_in  = stat.emit_last;
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      total_ff    <= total_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   // status to the controller
   assign stat.sym_ok       = int'(req_symbol) < SYMBOLS;
   assign stat.pend_nonzero = pend_cnt_ff != '0;
   assign stat.align_ge8    = align_total >= TOTAL_W'(BYTE_BITS);
   assign stat.emit_last    = total_ff < TOTAL_W'(2 * BYTE_BITS);
   assign stat.out_free     = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_packed_byte = out_byte_ff;
   assign rsp_last        = out_last_ff;

endmodule

[rtl/core/hbp_controller.sv]
// ----------------------------------------------------------------------------
// hbp_controller
// Sequencer for load, encode and flush items
// ----------------------------------------------------------------------------
module hbp_controller import hbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  hbp_stat_type     stat,
   output hbp_ctrl_type     ctrl
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ALIGN = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     ctrl.mem_wr = stat.sym_ok;
                  end
                  CMD_ENCODE: begin
                     if (stat.sym_ok) begin
                        ctrl.mem_rd = 1'b1;
                        state_in    = ST_ALIGN;
                     end
                  end
                  CMD_FLUSH: begin
                     ctrl.flush_ld = 1'b1;
                     if (stat.pend_nonzero) state_in = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ALIGN: begin
            ctrl.align_ld = 1'b1;
            state_in      = stat.align_ge8 ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // one byte per transfer slot, leave after the final byte
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               if (stat.emit_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/huffman_bit_packer_core.sv]
// ----------------------------------------------------------------------------
// huffman_bit_packer_core
// Huffman encoder back end: code table lookup and byte packing
//
//   channel  dir  fields                                  meaning
//   req_if   in   cmd, symbol, code_word, code_length     load / encode / flush
//   rsp_if   out  packed_byte, last                       one packed byte
//
// Load writes a table entry. Encode reads the table, aligns the code with
// the pending bits and emits each whole byte; flush pads out pending bits.
// The output byte register lets the next request be taken while the final
// byte of an item still waits for its transfer; a stalled response holds
// the byte loop. Reset clears pending bits and control; the code table is
// not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_bit_packer_core import hbp_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   hbp_req_if.sink    req_if,
   hbp_rsp_if.source  rsp_if
);

   hbp_ctrl_type ctrl;
   hbp_stat_type stat;
   logic         enc_take;

   // sequencer
   hbp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // table, alignment and output register
   hbp_datapath #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_symbol      (req_if.symbol),
      .req_code_word   (req_if.code_word),
      .req_code_length (req_if.code_length),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_packed_byte (rsp_if.packed_byte),
      .rsp_last        (rsp_if.last)
   );

   // accepted encode of a symbol inside the table
   assign enc_take = req_if.valid && req_if.ready && (req_if.cmd == CMD_ENCODE) && stat.sym_ok;

   // a byte is only loaded when the output register is free
   `ASSERT_PROP(a_emit_free, clock, reset, ctrl.emit |-> stat.out_free)
   // no request is taken while an item is in the byte loop
   `ASSERT_NEVER(a_ready_busy, clock, reset, req_if.ready && (ctrl.emit || ctrl.align_ld))
   // an accepted encode in range is aligned in the next cycle
   `ASSERT_PROP(a_enc_align, clock, reset, enc_take |=> ctrl.align_ld)
   // flush leaves no pending bits
   `ASSERT_PROP(a_flush_clr, clock, reset, ctrl.flush_ld |=> !stat.pend_nonzero)

endmodule
